[hw/rtl/sbts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_pkg: shared types and codes for the two-stack shared buffer
// Request and status codes, word widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sbts_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_LOW  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_HIGH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_LOW   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_HIGH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP_LOW  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DUMP_HIGH = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // stack select
    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic              side;        // stack addressed by this command
        logic              wr_en;       // push the input word
        logic              rd_en;       // read one store entry
        logic              rd_dump;     // read at dump index, else at top
        logic              cnt_inc;     // grow the selected stack
        logic              cnt_dec;     // shrink the selected stack
        logic              out_load;    // load the output register
        logic              out_use_rd;  // output word from read data, else zero
        logic [STAT_W-1:0] out_status;
        logic              out_last;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic low_empty;
        logic high_empty;
        logic full;       // both stacks together fill the store
        logic out_busy;   // output register holds a word not taken this cycle
        logic dump_last;  // dump index is the last entry of the selected stack
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/sbts_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_datapath: store, stack counters and output register
// Shared memory with registered read, both fill counters and the result word.
// ----------------------------------------------------------------------------
module sbts_datapath #(
    parameter int DEPTH = sbts_pkg::DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  sbts_pkg::t_cmd                 i_cmd,
    input  wire [$clog2(DEPTH)-1:0]        i_dump_idx,
    input  wire [sbts_pkg::DATA_W-1:0]     i_wr_data,
    output sbts_pkg::t_stat                o_stat,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [sbts_pkg::DATA_W-1:0]    o_out_data,
    output logic [sbts_pkg::STAT_W-1:0]    o_out_status,
    output logic                           o_out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [sbts_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [sbts_pkg::DATA_W-1:0] r_rd_data;
    logic [CW-1:0]               r_low_cnt;
    logic [CW-1:0]               r_high_cnt;
    logic [CW-1:0]               n_low_cnt;
    logic [CW-1:0]               n_high_cnt;
    logic                        r_out_valid;
    logic [sbts_pkg::DATA_W-1:0] r_out_data;
    logic [sbts_pkg::STAT_W-1:0] r_out_status;
    logic                        r_out_last;

    logic [CW:0]   w_total;
    logic [CW-1:0] w_pop_lo;
    logic [CW-1:0] w_pop_hi;
    logic [CW-1:0] w_idx_next;
    logic [CW-1:0] w_sel_cnt;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    // address arithmetic
    assign w_total    = {1'b0, r_low_cnt} + {1'b0, r_high_cnt};
    assign w_pop_lo   = r_low_cnt - CW'(1);
    assign w_pop_hi   = CW'(DEPTH) - r_high_cnt;
    assign w_idx_next = CW'(i_dump_idx) + CW'(1);
    assign w_sel_cnt  = (i_cmd.side == sbts_pkg::SIDE_HIGH) ? r_high_cnt : r_low_cnt;

    always_comb begin
        if (i_cmd.side == sbts_pkg::SIDE_HIGH) begin
            w_wr_addr = AW'(DEPTH - 1) - r_high_cnt[AW-1:0];
        end else begin
            w_wr_addr = r_low_cnt[AW-1:0];
        end
    end

    always_comb begin
        if (i_cmd.rd_dump) begin
            if (i_cmd.side == sbts_pkg::SIDE_HIGH) begin
                w_rd_addr = AW'(DEPTH - 1) - i_dump_idx;
            end else begin
                w_rd_addr = i_dump_idx;
            end
        end else begin
            if (i_cmd.side == sbts_pkg::SIDE_HIGH) begin
                w_rd_addr = w_pop_hi[AW-1:0];
            end else begin
                w_rd_addr = w_pop_lo[AW-1:0];
            end
        end
    end

    // shared store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // fill counters
    always_comb begin
        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        if (i_cmd.side == sbts_pkg::SIDE_HIGH) begin
            if (i_cmd.cnt_inc) begin
                n_high_cnt = r_high_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                n_high_cnt = r_high_cnt - CW'(1);
            end
        end else begin
            if (i_cmd.cnt_inc) begin
                n_low_cnt = r_low_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                n_low_cnt = r_low_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= i_cmd.out_use_rd ? r_rd_data : '0;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    // status to controller
    assign o_stat.low_empty  = (r_low_cnt == '0);
    assign o_stat.high_empty = (r_high_cnt == '0);
    assign o_stat.full       = (w_total == (CW + 1)'(DEPTH));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;
    assign o_stat.dump_last  = (w_idx_next == w_sel_cnt);

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule
`default_nettype wire

[hw/rtl/sbts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_ctrl: request sequencer
// Decodes each request, issues store and counter commands, walks dumps.
// ----------------------------------------------------------------------------
module sbts_ctrl #(
    parameter int DEPTH = sbts_pkg::DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire [sbts_pkg::REQ_W-1:0]    i_req_type,
    output logic                         o_in_ready,
    input  sbts_pkg::t_stat              i_stat,
    output sbts_pkg::t_cmd               o_cmd,
    output logic [$clog2(DEPTH)-1:0]     o_dump_idx
);

    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;  // pop read done, waiting to load
    localparam logic [1:0] S_DRD  = 2'd2;  // dump: read entry
    localparam logic [1:0] S_DWR  = 2'd3;  // dump: load entry

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic          r_side;
    logic          n_side;
    logic          w_accept;
    logic          w_req_side;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.out_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_req_side = (i_req_type == sbts_pkg::REQ_PUSH_HIGH) ||
                        (i_req_type == sbts_pkg::REQ_POP_HIGH)  ||
                        (i_req_type == sbts_pkg::REQ_DUMP_HIGH);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_side  = r_side;
        o_cmd   = '0;
        o_cmd.side = r_side;
        case (r_state)
            S_IDLE: begin
                o_cmd.side = w_req_side;
                if (w_accept) begin
                    n_side = w_req_side;
                    case (i_req_type)
                        sbts_pkg::REQ_PUSH_LOW, sbts_pkg::REQ_PUSH_HIGH: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = sbts_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.wr_en      = 1'b1;
                                o_cmd.cnt_inc    = 1'b1;
                                o_cmd.out_status = sbts_pkg::ST_OK;
                            end
                        end
                        sbts_pkg::REQ_POP_LOW, sbts_pkg::REQ_POP_HIGH: begin
                            if (w_req_side ? i_stat.high_empty : i_stat.low_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = sbts_pkg::ST_UNDERFLOW;
                            end else begin
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.cnt_dec = 1'b1;
                                n_state       = S_POP;
                            end
                        end
                        sbts_pkg::REQ_DUMP_LOW, sbts_pkg::REQ_DUMP_HIGH: begin
                            if (w_req_side ? i_stat.high_empty : i_stat.low_empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = sbts_pkg::ST_UNDERFLOW;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DRD;
                            end
                        end
                        default: begin
                            // unknown request: dropped
                        end
                    endcase
                end
            end
            S_POP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_use_rd = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = sbts_pkg::ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_DRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_dump = 1'b1;
                n_state       = S_DWR;
            end
            S_DWR: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_use_rd = 1'b1;
                    o_cmd.out_last   = i_stat.dump_last;
                    o_cmd.out_status = sbts_pkg::ST_OK;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_side  <= sbts_pkg::SIDE_LOW;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_side  <= n_side;
        end
    end

    assign o_dump_idx = r_idx;

endmodule
`default_nettype wire

[hw/rtl/shared_buffer_two_stacks.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shared_buffer_two_stacks: two LIFO stacks in one shared store
// Low stack grows up from entry 0, high stack grows down from entry DEPTH-1.
//
// Input stream: s_axis_tuser carries the request (push, pop or dump on
// either stack), s_axis_tdata the word to push. Output stream: one word per
// result, m_axis_tuser the status (ok, overflow, underflow), m_axis_tdata
// the popped or dumped word (zero otherwise), m_axis_tlast marks the final
// word caused by a request.
// Push and any overflow/underflow result appear in the cycle after
// acceptance; a pop result passes through the registered store read, then
// the output register; each dump word is read from the store, then loaded.
// Pushes and failed requests can be taken every cycle while the receiver
// takes each word; a pop or dump takes no new request until its last word
// is loaded, the controller walking each dump entry read then load.
// Unknown requests are dropped. Reset clears counts, state and output valid.
// A stalled receiver holds the output register; no new request is taken
// until the pending word is taken or is taken in the same cycle.
// ----------------------------------------------------------------------------
module shared_buffer_two_stacks #(
    parameter int DEPTH = sbts_pkg::DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [sbts_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] push_value
    input  wire [sbts_pkg::REQ_W-1:0]     s_axis_tuser,   // [2:0] req_type
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [sbts_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] read_value
    output logic [sbts_pkg::STAT_W-1:0]   m_axis_tuser,   // [1:0] status
    output logic                          m_axis_tlast    // is_last
);

    sbts_pkg::t_cmd             w_cmd;
    sbts_pkg::t_stat            w_stat;
    logic [$clog2(DEPTH)-1:0]   w_dump_idx;

    sbts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_dump_idx (w_dump_idx)
    );

    sbts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_dump_idx   (w_dump_idx),
        .i_wr_data    (s_axis_tdata),
        .o_stat       (w_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule
`default_nettype wire
